### design/piecewise_poly_trajectory_eval_defines.svh
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_eval_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_POLY_TRAJECTORY_EVAL_DEFINES_SVH
`define PIECEWISE_POLY_TRAJECTORY_EVAL_DEFINES_SVH

// same-cycle implication
`define PPTE_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("ppte assertion failed");

// next-cycle implication
`define PPTE_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("ppte assertion failed");

`endif

### design/ppte_pkg.sv
// ----------------------------------------------------------------------------
// ppte_pkg
// types, codes and constants of the trajectory evaluator
// ----------------------------------------------------------------------------
package ppte_pkg;

	localparam int DATA_W   = 48;
	localparam int TIME_W   = 32;
	localparam int CHUNK_W  = 16;
	localparam int OUT_AXES = 3;
	localparam int SEG_W    = 4;
	localparam int CFG_W    = 5;

	localparam logic [1:0] FUNC_LOAD_DUR  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_COEF = 2'd1;
	localparam logic [1:0] FUNC_QUERY     = 2'd2;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 48'sh8000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_RD,
		ST_S_CMP,
		ST_C_RD,
		ST_C_LD,
		ST_W_MUL,
		ST_W_ACC,
		ST_W_FIN,
		ST_T_MUL_LO,
		ST_T_RND,
		ST_T_MUL_HI,
		ST_T_ADD,
		ST_T_FIN,
		ST_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_LOAD,
		ALU_MUL,
		ALU_SHADD,
		ALU_RND,
		ALU_ADD
	} alu_op_t;

	typedef struct packed {
		alu_op_t                   op;
		logic [CHUNK_W-1:0]        mul_b;
		logic signed [DATA_W-1:0]  ld_val;
		logic signed [DATA_W-1:0]  add_val;
	} alu_ctl_t;

	// falling factorial j!/(j-d)!
	function automatic logic [63:0] fall_fact(input int j, input int d);
		logic [63:0] w;
		w = 64'd1;
		for (int i = 0; i < d; i++)
			w = w * 64'(j - i);
		return w;
	endfunction

endpackage

### design/ppte_store.sv
// ----------------------------------------------------------------------------
// ppte_store
// segment duration and coefficient memories, registered reads
// ----------------------------------------------------------------------------
module ppte_store #(
	parameter int DUR_DEPTH  = 16,
	parameter int COEF_DEPTH = 384
) (
	input  logic                                          clk,
	input  logic                                          dur_we,
	input  logic [(DUR_DEPTH > 1 ? $clog2(DUR_DEPTH) : 1)-1:0] dur_waddr,
	input  logic [ppte_pkg::TIME_W-1:0]                   dur_wdata,
	input  logic [(DUR_DEPTH > 1 ? $clog2(DUR_DEPTH) : 1)-1:0] dur_raddr,
	output logic [ppte_pkg::TIME_W-1:0]                   rd_dur_q,
	input  logic                                          coef_we,
	input  logic [$clog2(COEF_DEPTH)-1:0]                 coef_waddr,
	input  logic signed [ppte_pkg::DATA_W-1:0]            coef_wdata,
	input  logic [$clog2(COEF_DEPTH)-1:0]                 coef_raddr,
	output logic signed [ppte_pkg::DATA_W-1:0]            rd_coef_q
);
	import ppte_pkg::*;

	logic [TIME_W-1:0]        dur_mem  [DUR_DEPTH];
	logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];

	always_ff @(posedge clk) begin
		if (dur_we)
			dur_mem[dur_waddr] <= dur_wdata;
		rd_dur_q <= dur_mem[dur_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_waddr] <= coef_wdata;
		rd_coef_q <= coef_mem[coef_raddr];
	end

endmodule

### design/ppte_alu.sv
// ----------------------------------------------------------------------------
// ppte_alu
// shared 48x16 magnitude multiplier with accumulator and saturation
// ----------------------------------------------------------------------------
module ppte_alu (
	input  logic                              clk,
	input  ppte_pkg::alu_ctl_t                ctl,
	output logic signed [ppte_pkg::DATA_W-1:0] sat_val,
	output logic signed [ppte_pkg::DATA_W-1:0] sum_val
);
	import ppte_pkg::*;

	localparam logic [64:0] NEG_LIM = 65'h0_8000_0000_0000;
	localparam logic [64:0] POS_LIM = 65'h0_7FFF_FFFF_FFFF;

	logic              neg_q;
	logic [DATA_W-1:0] mag_q;
	logic [63:0]       prod_q;
	logic [64:0]       acc_q;
	logic              ovf_q;
	logic signed [DATA_W:0] sum_w;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ALU_NOP: begin
			end
			ALU_LOAD: begin
				neg_q <= ctl.ld_val[DATA_W-1];
				mag_q <= ctl.ld_val[DATA_W-1] ? DATA_W'(-ctl.ld_val) : DATA_W'(ctl.ld_val);
				acc_q <= '0;
				ovf_q <= 1'b0;
			end
			ALU_MUL: begin
				prod_q <= 64'(mag_q) * 64'(ctl.mul_b);
			end
			ALU_SHADD: begin
				ovf_q <= ovf_q | (acc_q[64:48] != '0);
				acc_q <= {1'b0, acc_q[47:0], 16'b0} + {1'b0, prod_q};
			end
			ALU_RND: begin
				acc_q <= ({1'b0, prod_q} + 65'h8000) >> CHUNK_W;
			end
			ALU_ADD: begin
				acc_q <= acc_q + {1'b0, prod_q};
			end
		endcase
	end

	always_comb begin
		if (neg_q) begin
			if (ovf_q || acc_q > NEG_LIM)
				sat_val = SAT_MIN;
			else
				sat_val = -$signed(acc_q[DATA_W-1:0]);
		end else begin
			if (ovf_q || acc_q > POS_LIM)
				sat_val = SAT_MAX;
			else
				sat_val = $signed(acc_q[DATA_W-1:0]);
		end
	end

	always_comb begin
		sum_w = (DATA_W+1)'(sat_val) + (DATA_W+1)'(ctl.add_val);
		if (sum_w > (DATA_W+1)'(SAT_MAX))
			sum_val = SAT_MAX;
		else if (sum_w < (DATA_W+1)'(SAT_MIN))
			sum_val = SAT_MIN;
		else
			sum_val = sum_w[DATA_W-1:0];
	end

endmodule

### design/piecewise_poly_trajectory_eval.sv
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_eval
// segment search and Horner evaluation of three-axis polynomial trajectories
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// cmd       in         cmd_valid/cmd_stall   func .. deriv_order
// res       out        res_valid/res_stall   state_x .. past_end
// cfg       in         cfg_we                cfg_wdata (segments in use)
//
// a query searches the segments in use, then runs Horner over each axis's coefficients;
// each term scales its coefficient by K weight chunks (K = 1 for N = 8).
// the single 48x16 multiplier sets the per-term cost.
// cmd_stall is high while a query runs; a pending result does not block loads.
// memories have no reset; segments in use resets to 1.
// ----------------------------------------------------------------------------
module piecewise_poly_trajectory_eval #(
	parameter int MAX_SEGMENTS = 16,
	parameter int NUM_COEFFS   = 8,
	parameter int NUM_AXES     = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ppte_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  logic [1:0]                            func,
	input  logic [3:0]                            seg_index,
	input  logic [1:0]                            axis,
	input  logic [2:0]                            coeff_index,
	input  logic signed [ppte_pkg::DATA_W-1:0]    coeff_value,
	input  logic [ppte_pkg::TIME_W-1:0]           duration,
	input  logic [ppte_pkg::TIME_W-1:0]           query_time,
	input  logic [2:0]                            deriv_order,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [ppte_pkg::DATA_W-1:0]    state_x,
	output logic signed [ppte_pkg::DATA_W-1:0]    state_y,
	output logic signed [ppte_pkg::DATA_W-1:0]    state_z,
	output logic [ppte_pkg::SEG_W-1:0]            segment_found,
	output logic                                  past_end
);
	import ppte_pkg::*;

	localparam int COEF_DEPTH = MAX_SEGMENTS * NUM_AXES * NUM_COEFFS;
	localparam int IW   = MAX_SEGMENTS > 1 ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CAW  = $clog2(COEF_DEPTH);
	localparam int CW   = $clog2(NUM_COEFFS);
	localparam int SW   = TIME_W + 1 + $clog2(MAX_SEGMENTS);
	localparam logic [63:0] WMAX = fall_fact(NUM_COEFFS - 1, NUM_COEFFS - 1);
	localparam int WW   = $clog2(WMAX + 64'd1);
	localparam int K    = (WW + CHUNK_W - 1) / CHUNK_W;
	localparam int KW   = K > 1 ? $clog2(K) : 1;

	seq_state_t state_q, state_d;

	logic [CFG_W-1:0]         seg_use_q;
	logic [TIME_W-1:0]        qt_q;
	logic [CW-1:0]            d_q;
	logic                     dbig_q;
	logic [IW-1:0]            nlast_q;
	logic [IW-1:0]            i_q;
	logic [SW-1:0]            start_q;
	logic [TIME_W-1:0]        t_q;
	logic                     past_q;
	logic [1:0]               axis_q;
	logic [CW-1:0]            j_q;
	logic [KW-1:0]            k_q;
	logic signed [DATA_W-1:0] h_q;
	logic signed [DATA_W-1:0] wv_q;
	logic signed [DATA_W-1:0] res_q [OUT_AXES];
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [SEG_W-1:0]         out_seg_q;
	logic                     out_past_q;

	logic                     cmd_acc;
	logic                     out_free;
	logic [IW-1:0]            nlast_d;
	logic [SW-1:0]            dur_sum;
	logic                     seg_pass;
	logic                     seg_last;
	logic                     w_first;
	logic                     j_end;
	logic                     axis_last;
	logic                     step_done;
	logic signed [DATA_W-1:0] h_next;
	logic [WW-1:0]            wt_tbl [NUM_COEFFS][NUM_COEFFS];
	logic [K*CHUNK_W-1:0]     wt_pad;
	logic [CHUNK_W-1:0]       wt_chunk;

	logic                     dur_we, coef_we;
	logic [IW-1:0]            dur_waddr;
	logic [CAW-1:0]           coef_waddr, coef_raddr;
	logic [TIME_W-1:0]        rd_dur_q;
	logic signed [DATA_W-1:0] rd_coef_q;
	alu_ctl_t                 alu_ctl;
	logic signed [DATA_W-1:0] sat_val, sum_val;

	for (genvar gj = 0; gj < NUM_COEFFS; gj++) begin : g_wj
		for (genvar gd = 0; gd < NUM_COEFFS; gd++) begin : g_wd
			assign wt_tbl[gj][gd] = WW'(fall_fact(gj, gd));
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	assign dur_sum   = start_q + SW'(rd_dur_q);
	assign seg_pass  = SW'(qt_q) >= dur_sum;
	assign seg_last  = (i_q == nlast_q);
	assign w_first   = (j_q == CW'(NUM_COEFFS - 1));
	assign j_end     = (j_q == d_q);
	assign axis_last = (axis_q == 2'(NUM_AXES - 1));
	assign step_done = (state_q == ST_W_FIN && w_first) || state_q == ST_T_FIN;
	assign h_next    = (state_q == ST_T_FIN) ? sum_val : sat_val;
	assign wt_pad    = (K*CHUNK_W)'(wt_tbl[j_q][d_q]);
	assign wt_chunk  = wt_pad[k_q*CHUNK_W +: CHUNK_W];

	always_comb begin
		if (seg_use_q == '0)
			nlast_d = '0;
		else if (32'(seg_use_q) > MAX_SEGMENTS)
			nlast_d = IW'(MAX_SEGMENTS - 1);
		else
			nlast_d = IW'(seg_use_q - CFG_W'(1));
	end

	// load ports
	assign dur_we     = cmd_acc && func == FUNC_LOAD_DUR && 32'(seg_index) < MAX_SEGMENTS;
	assign coef_we    = cmd_acc && func == FUNC_LOAD_COEF && 32'(seg_index) < MAX_SEGMENTS
		&& 32'(axis) < NUM_AXES && 32'(coeff_index) < NUM_COEFFS;
	assign dur_waddr  = IW'(seg_index);
	assign coef_waddr = CAW'((32'(seg_index) * NUM_AXES + 32'(axis)) * NUM_COEFFS
		+ 32'(coeff_index));
	assign coef_raddr = CAW'((32'(i_q) * NUM_AXES + 32'(axis_q)) * NUM_COEFFS + 32'(j_q));

	ppte_store #(
		.DUR_DEPTH  (MAX_SEGMENTS),
		.COEF_DEPTH (COEF_DEPTH)
	) u_store (
		.clk        (clk),
		.dur_we     (dur_we),
		.dur_waddr  (dur_waddr),
		.dur_wdata  (duration),
		.dur_raddr  (i_q),
		.rd_dur_q   (rd_dur_q),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coeff_value),
		.coef_raddr (coef_raddr),
		.rd_coef_q  (rd_coef_q)
	);

	ppte_alu u_alu (
		.clk     (clk),
		.ctl     (alu_ctl),
		.sat_val (sat_val),
		.sum_val (sum_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_use_q   <= CFG_W'(1);
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				seg_use_q <= cfg_wdata;
			if (state_q == ST_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d         = state_q;
		alu_ctl.op      = ALU_NOP;
		alu_ctl.mul_b   = '0;
		alu_ctl.ld_val  = rd_coef_q;
		alu_ctl.add_val = wv_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && func == FUNC_QUERY)
					state_d = ST_S_RD;
			end
			ST_S_RD: begin
				state_d = ST_S_CMP;
			end
			ST_S_CMP: begin
				if (seg_pass && !seg_last)
					state_d = ST_S_RD;
				else
					state_d = dbig_q ? ST_DONE : ST_C_RD;
			end
			ST_C_RD: begin
				state_d = ST_C_LD;
			end
			ST_C_LD: begin
				alu_ctl.op = ALU_LOAD;
				state_d    = ST_W_MUL;
			end
			ST_W_MUL: begin
				alu_ctl.op    = ALU_MUL;
				alu_ctl.mul_b = wt_chunk;
				state_d       = ST_W_ACC;
			end
			ST_W_ACC: begin
				alu_ctl.op = ALU_SHADD;
				state_d    = (k_q == '0) ? ST_W_FIN : ST_W_MUL;
			end
			ST_W_FIN: begin
				if (w_first) begin
					state_d = (j_end && axis_last) ? ST_DONE : ST_C_RD;
				end else begin
					alu_ctl.op     = ALU_LOAD;
					alu_ctl.ld_val = h_q;
					state_d        = ST_T_MUL_LO;
				end
			end
			ST_T_MUL_LO: begin
				alu_ctl.op    = ALU_MUL;
				alu_ctl.mul_b = t_q[CHUNK_W-1:0];
				state_d       = ST_T_RND;
			end
			ST_T_RND: begin
				alu_ctl.op = ALU_RND;
				state_d    = ST_T_MUL_HI;
			end
			ST_T_MUL_HI: begin
				alu_ctl.op    = ALU_MUL;
				alu_ctl.mul_b = t_q[TIME_W-1:CHUNK_W];
				state_d       = ST_T_ADD;
			end
			ST_T_ADD: begin
				alu_ctl.op = ALU_ADD;
				state_d    = ST_T_FIN;
			end
			ST_T_FIN: begin
				state_d = (j_end && axis_last) ? ST_DONE : ST_C_RD;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_acc && func == FUNC_QUERY) begin
			qt_q    <= query_time;
			d_q     <= CW'(deriv_order);
			dbig_q  <= 32'(deriv_order) >= NUM_COEFFS;
			nlast_q <= nlast_d;
			i_q     <= '0;
			start_q <= '0;
			for (int a = 0; a < OUT_AXES; a++)
				res_q[a] <= '0;
		end
		if (state_q == ST_S_CMP) begin
			axis_q <= '0;
			j_q    <= CW'(NUM_COEFFS - 1);
			if (seg_pass) begin
				start_q <= dur_sum;
				if (seg_last) begin
					i_q    <= '0;
					t_q    <= '0;
					past_q <= 1'b1;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end else begin
				t_q    <= TIME_W'(SW'(qt_q) - start_q);
				past_q <= 1'b0;
			end
		end
		if (state_q == ST_C_LD)
			k_q <= KW'(K - 1);
		if (state_q == ST_W_ACC && k_q != '0)
			k_q <= k_q - KW'(1);
		if (state_q == ST_W_FIN && !w_first)
			wv_q <= sat_val;
		if (step_done) begin
			h_q <= h_next;
			if (j_end) begin
				res_q[axis_q] <= h_next;
				axis_q        <= axis_q + 2'd1;
				j_q           <= CW'(NUM_COEFFS - 1);
			end else begin
				j_q <= j_q - CW'(1);
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_x_q    <= res_q[0];
			out_y_q    <= res_q[1];
			out_z_q    <= res_q[2];
			out_seg_q  <= SEG_W'(i_q);
			out_past_q <= past_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign state_x       = out_x_q;
	assign state_y       = out_y_q;
	assign state_z       = out_z_q;
	assign segment_found = out_seg_q;
	assign past_end      = out_past_q;

endmodule

### design/ppte_checker.sv
// ----------------------------------------------------------------------------
// ppte_checker
// port-level checks of the trajectory evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "piecewise_poly_trajectory_eval_defines.svh"

module ppte_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cmd_valid,
	input logic                                  cmd_stall,
	input logic [1:0]                            func,
	input logic                                  res_valid,
	input logic                                  res_stall,
	input logic signed [ppte_pkg::DATA_W-1:0]    state_x,
	input logic signed [ppte_pkg::DATA_W-1:0]    state_y,
	input logic signed [ppte_pkg::DATA_W-1:0]    state_z,
	input logic [ppte_pkg::SEG_W-1:0]            segment_found,
	input logic                                  past_end
);
	import ppte_pkg::*;

	logic [3*DATA_W+SEG_W:0] res_bus;

	assign res_bus = {state_x, state_y, state_z, segment_found, past_end};

	// stalled result stays
	`PPTE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid)
	`PPTE_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && res_stall, $stable(res_bus))
	// past the end always reports segment zero
	`PPTE_ASSERT_IMPL(a_past_seg0, clk, arst_n, res_valid && past_end, segment_found == 4'd0)
	// a query transaction keeps the block busy
	`PPTE_ASSERT_NEXT(a_query_busy, clk, arst_n, cmd_valid && !cmd_stall && func == FUNC_QUERY, cmd_stall)
	// a new result only comes out of a running query
	`PPTE_ASSERT_IMPL(a_res_after_work, clk, arst_n, $rose(res_valid), $past(cmd_stall))

endmodule

bind piecewise_poly_trajectory_eval ppte_checker u_ppte_checker (.*);

### tb/piecewise_poly_trajectory_eval_test.sv
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_eval_test
// self-checking bench for the trajectory evaluator: fills the duration and
// coefficient stores, then runs directed and random loads and queries under
// several segment counts, with random idling on both channels. a behavioral
// predictor of the segment search and Horner evaluation supplies the expected
// state of every query, compared field by field in acceptance order.
// ----------------------------------------------------------------------------
module piecewise_poly_trajectory_eval_test;
	import ppte_pkg::*;

	localparam int NUM_SEGS     = 16;
	localparam int NUM_TERMS    = 8;
	localparam int NUM_AX       = 3;
	localparam int SETTLE       = 300;
	localparam int LONG_HOLD    = 2000;
	localparam int PHASE_ITEMS  = 145;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] AXIS_X      = 2'd0;
	localparam logic [1:0] AXIS_Y      = 2'd1;
	localparam logic [1:0] AXIS_Z      = 2'd2;
	localparam logic [1:0] AXIS_UNUSED = 2'd3;
	localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint MIN48 = -MAX48 - 1;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  seg_index;
		logic [1:0]  axis;
		logic [2:0]  coeff_index;
		logic [47:0] coeff_value;
		logic [31:0] duration;
		logic [31:0] query_time;
		logic [2:0]  deriv_order;
	} traj_cmd_t;

	typedef struct packed {
		logic [47:0] x;
		logic [47:0] y;
		logic [47:0] z;
		logic [3:0]  seg;
		logic        past;
	} traj_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [1:0] func = '0;
	logic [3:0] seg_index = '0;
	logic [1:0] axis = '0;
	logic [2:0] coeff_index = '0;
	logic signed [DATA_W-1:0] coeff_value = '0;
	logic [TIME_W-1:0] duration = '0;
	logic [TIME_W-1:0] query_time = '0;
	logic [2:0] deriv_order = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [DATA_W-1:0] state_x, state_y, state_z;
	logic [SEG_W-1:0] segment_found;
	logic past_end;

	piecewise_poly_trajectory_eval dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.func(func),
		.seg_index(seg_index),
		.axis(axis),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.duration(duration),
		.query_time(query_time),
		.deriv_order(deriv_order),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.state_x(state_x),
		.state_y(state_y),
		.state_z(state_z),
		.segment_found(segment_found),
		.past_end(past_end)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0] seg_len [NUM_SEGS];
	longint coef_tab [NUM_SEGS][NUM_AX][NUM_TERMS];
	logic [4:0] seg_count = 5'd1;

	// stimulus-side view of durations and segment count
	logic [31:0] gen_len [NUM_SEGS];
	logic [4:0] gen_count = 5'd1;

	traj_cmd_t cmd_queue [$];
	traj_state_t expected_states [$];
	traj_cmd_t cur_cmd;
	traj_state_t exp_state;
	int errors = 0;
	int unsigned send_wait = 0, send_quiet = 0;
	int unsigned stall_left = 0, stall_quiet = 0;
	logic want_hold = 1'b0;
	logic hold_done = 1'b0;

	function automatic longint clamp48(input longint v);
		if (v > MAX48)
			return MAX48;
		if (v < MIN48)
			return MIN48;
		return v;
	endfunction

	// Q16.32 times Q16.16, magnitude rounded half away from zero
	function automatic longint time_mul(input longint a, input logic [31:0] t);
		logic [63:0] mag, hi, lo, m;
		logic neg;
		neg = a < 0;
		mag = neg ? 64'(-a) : 64'(a);
		hi = {48'd0, t[31:16]};
		lo = {48'd0, t[15:0]};
		m = mag * hi + ((mag * lo + 64'h8000) >> 16);
		if (neg)
			return (m > 64'h0000_8000_0000_0000) ? MIN48 : -longint'(m);
		return (m > 64'h0000_7FFF_FFFF_FFFF) ? MAX48 : longint'(m);
	endfunction

	function automatic longint falling_weight(input int j, input int d);
		longint w;
		w = 1;
		for (int i = 0; i < d; i++)
			w = w * longint'(j - i);
		return w;
	endfunction

	function automatic longint scale_coef(input longint c, input longint w);
		if (c > MAX48 / w)
			return MAX48;
		if (c < MIN48 / w)
			return MIN48;
		return c * w;
	endfunction

	function automatic longint axis_value(input int seg, input int ax, input logic [31:0] t,
		input int d);
		longint acc;
		if (d >= NUM_TERMS)
			return 0;
		acc = scale_coef(coef_tab[seg][ax][NUM_TERMS-1], falling_weight(NUM_TERMS - 1, d));
		for (int j = NUM_TERMS - 1; j > d; j--)
			acc = clamp48(time_mul(acc, t) + scale_coef(coef_tab[seg][ax][j-1],
				falling_weight(j - 1, d)));
		return acc;
	endfunction

	function automatic traj_state_t predict_state(input logic [31:0] qt, input logic [2:0] order);
		traj_state_t s;
		logic [63:0] start;
		logic [31:0] tseg;
		int n, seg;
		n = int'(seg_count);
		if (n < 1)
			n = 1;
		if (n > NUM_SEGS)
			n = NUM_SEGS;
		start = '0;
		tseg = '0;
		seg = 0;
		s.past = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ({32'd0, qt} >= start + seg_len[i]) begin
				start = start + seg_len[i];
			end else begin
				tseg = 32'({32'd0, qt} - start);
				seg = i;
				s.past = 1'b0;
				break;
			end
		end
		s.seg = 4'(seg);
		s.x = 48'(axis_value(seg, AXIS_X, tseg, int'(order)));
		s.y = 48'(axis_value(seg, AXIS_Y, tseg, int'(order)));
		s.z = 48'(axis_value(seg, AXIS_Z, tseg, int'(order)));
		return s;
	endfunction

	task automatic absorb_command(input traj_cmd_t c);
		case (c.func)
			FUNC_LOAD_DUR: begin
				seg_len[c.seg_index] = c.duration;
			end
			FUNC_LOAD_COEF: begin
				if (c.axis < NUM_AX)
					coef_tab[c.seg_index][c.axis][c.coeff_index] = longint'($signed(c.coeff_value));
			end
			FUNC_QUERY: begin
				expected_states = {expected_states,
					predict_state(c.query_time, c.deriv_order)};
			end
			default: ;
		endcase
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 100);
	endfunction

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				absorb_command(cur_cmd);
			if (!cmd_valid || !cmd_stall) begin
				if (send_wait != 0) begin
					send_wait--;
					cmd_valid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					cur_cmd = cmd_queue.pop_front();
					func <= cur_cmd.func;
					seg_index <= cur_cmd.seg_index;
					axis <= cur_cmd.axis;
					coeff_index <= cur_cmd.coeff_index;
					coeff_value <= cur_cmd.coeff_value;
					duration <= cur_cmd.duration;
					query_time <= cur_cmd.query_time;
					deriv_order <= cur_cmd.deriv_order;
					cmd_valid <= 1'b1;
					if (send_quiet != 0) begin
						send_quiet--;
					end else begin
						send_wait = pick_gap();
						if ($urandom_range(199) == 0)
							send_quiet = 80;
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_states.size() == 0) begin
					$error("result transaction with no query pending");
					errors++;
				end else begin
					exp_state = expected_states.pop_front();
					if (state_x !== exp_state.x) begin
						$error("state_x expected %h actual %h", exp_state.x, state_x);
						errors++;
					end
					if (state_y !== exp_state.y) begin
						$error("state_y expected %h actual %h", exp_state.y, state_y);
						errors++;
					end
					if (state_z !== exp_state.z) begin
						$error("state_z expected %h actual %h", exp_state.z, state_z);
						errors++;
					end
					if (segment_found !== exp_state.seg) begin
						$error("segment_found expected %0d actual %0d", exp_state.seg,
							segment_found);
						errors++;
					end
					if (past_end !== exp_state.past) begin
						$error("past_end expected %0d actual %0d", exp_state.past, past_end);
						errors++;
					end
				end
			end
			if (want_hold && !hold_done) begin
				stall_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (stall_quiet != 0) begin
					stall_quiet--;
				end else begin
					stall_left = pick_gap();
					if ($urandom_range(199) == 0)
						stall_quiet = 80;
				end
			end
		end
	end

	// stimulus helpers
	function automatic traj_cmd_t noise_cmd();
		traj_cmd_t c;
		c.func = 2'($urandom_range(3));
		c.seg_index = 4'($urandom_range(15));
		c.axis = 2'($urandom_range(3));
		c.coeff_index = 3'($urandom_range(7));
		c.coeff_value = {16'($urandom()), 32'($urandom())};
		c.duration = $urandom();
		c.query_time = $urandom();
		c.deriv_order = 3'($urandom_range(7));
		return c;
	endfunction

	function automatic traj_cmd_t query_cmd(input logic [31:0] t, input logic [2:0] d);
		traj_cmd_t c;
		c = noise_cmd();
		c.func = FUNC_QUERY;
		c.query_time = t;
		c.deriv_order = d;
		return c;
	endfunction

	function automatic traj_cmd_t coef_cmd(input logic [3:0] seg, input logic [1:0] ax,
		input logic [2:0] ci, input logic [47:0] v);
		traj_cmd_t c;
		c = noise_cmd();
		c.func = FUNC_LOAD_COEF;
		c.seg_index = seg;
		c.axis = ax;
		c.coeff_index = ci;
		c.coeff_value = v;
		return c;
	endfunction

	function automatic traj_cmd_t dur_cmd(input logic [3:0] seg, input logic [31:0] v);
		traj_cmd_t c;
		c = noise_cmd();
		c.func = FUNC_LOAD_DUR;
		c.seg_index = seg;
		c.duration = v;
		return c;
	endfunction

	task automatic queue_cmd(input traj_cmd_t c);
		cmd_queue = {cmd_queue, c};
		if (c.func == FUNC_LOAD_DUR)
			gen_len[c.seg_index] = c.duration;
	endtask

	function automatic logic [63:0] gen_start(input int k);
		logic [63:0] s;
		s = '0;
		for (int i = 0; i < k; i++)
			s = s + gen_len[i];
		return s;
	endfunction

	function automatic logic [31:0] clip32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [47:0] pick_coef();
		logic signed [47:0] v;
		case ($urandom_range(99))
			0, 1: v = SAT_MAX;
			2, 3: v = SAT_MIN;
			4: v = '0;
			5: v = '1;
			6: v = 48'sd1;
			default: begin
				v = {16'($urandom()), 32'($urandom())};
				v = v >>> $urandom_range(47);
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 13)
			return $urandom();
		if (r < 15)
			return 32'hFFFF_FFFF;
		return $urandom_range(32'h0004_0000);
	endfunction

	function automatic logic [31:0] pick_time();
		logic [63:0] total, mark;
		int unsigned r;
		int n;
		n = int'(gen_count);
		if (n < 1)
			n = 1;
		if (n > NUM_SEGS)
			n = NUM_SEGS;
		total = gen_start(n);
		r = $urandom_range(99);
		if (r < 10)
			return $urandom();
		if (r < 25) begin
			// segment edges, exactly or one tick either side
			mark = gen_start($urandom_range(n));
			case ($urandom_range(2))
				0: mark = (mark == 0) ? mark : mark - 1;
				1: mark = mark + 1;
				default: ;
			endcase
			return clip32(mark);
		end
		mark = total + (total >> 3);
		return clip32({32'($urandom()), 32'($urandom())} % (mark + 1));
	endfunction

	function automatic traj_cmd_t random_cmd();
		traj_cmd_t c;
		int unsigned r;
		c = noise_cmd();
		r = $urandom_range(99);
		if (r < 45) begin
			c.func = FUNC_QUERY;
			c.query_time = pick_time();
		end else if (r < 72) begin
			c.func = FUNC_LOAD_COEF;
			c.axis = 2'($urandom_range(2));
			c.coeff_value = pick_coef();
		end else if (r < 92) begin
			c.func = FUNC_LOAD_DUR;
			c.duration = pick_duration();
		end else if (r < 96) begin
			c.func = FUNC_UNUSED;
		end else begin
			c.func = FUNC_LOAD_COEF;
			c.axis = AXIS_UNUSED;
		end
		return c;
	endfunction

	task automatic drain();
		@(negedge clk);
		while (cmd_queue.size() != 0 || cmd_valid || expected_states.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_segments(input logic [4:0] v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		seg_count = v;
		gen_count = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [4:0] phase_segs [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2, 5'd16};

	initial begin
		traj_cmd_t odd_cmd;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_segments(5'd16);

		// fill every store entry before the first query
		for (int s = 0; s < NUM_SEGS; s++) begin
			if (s == 3)
				queue_cmd(dur_cmd(4'(s), 32'd0));
			else if (s == NUM_SEGS - 1)
				queue_cmd(dur_cmd(4'(s), 32'hFFFF_FFFF));
			else
				queue_cmd(dur_cmd(4'(s), $urandom_range(32'h0001_0000, 32'h0003_0000)));
		end
		for (int s = 0; s < NUM_SEGS; s++)
			for (int a = 0; a < NUM_AX; a++)
				for (int k = 0; k < NUM_TERMS; k++)
					queue_cmd(coef_cmd(4'(s), 2'(a), 3'(k), pick_coef()));

		// directed
		queue_cmd(query_cmd(32'd0, 3'd0));
		queue_cmd(query_cmd(32'd0, 3'd7));
		queue_cmd(query_cmd(32'(gen_start(3)), 3'd1));
		queue_cmd(query_cmd(32'(gen_start(3) - 1), 3'd2));
		queue_cmd(query_cmd(32'hFFFF_FFFF, 3'd0));
		queue_cmd(coef_cmd(4'd0, AXIS_X, 3'd7, SAT_MAX));
		queue_cmd(coef_cmd(4'd0, AXIS_Y, 3'd7, SAT_MIN));
		queue_cmd(coef_cmd(4'd0, AXIS_Z, 3'd0, SAT_MIN));
		queue_cmd(query_cmd(32'd0, 3'd7));
		queue_cmd(query_cmd(32'd1, 3'd3));
		odd_cmd = noise_cmd();
		odd_cmd.func = FUNC_UNUSED;
		queue_cmd(odd_cmd);
		queue_cmd(coef_cmd(4'd0, AXIS_UNUSED, 3'd0, 48'sd1));
		queue_cmd(query_cmd(32'd0, 3'd0));
		queue_cmd(dur_cmd(4'(NUM_SEGS - 1), 32'd0));
		queue_cmd(query_cmd(32'hFFFF_FFFF, 3'd4));
		queue_cmd(query_cmd(32'(gen_start(NUM_SEGS)), 3'd5));
		queue_cmd(query_cmd(32'(gen_start(NUM_SEGS) - 1), 3'd6));

		// random phases, one segment count each
		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				set_segments(5'($urandom_range(31)));
			else
				set_segments(phase_segs[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_cmd(random_cmd());
			if (p == 0)
				want_hold <= 1'b1;
		end

		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20000000;
		$error("run timed out");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/ppte_pkg.sv
design/ppte_store.sv
design/ppte_alu.sv
design/piecewise_poly_trajectory_eval.sv
design/ppte_checker.sv
tb/piecewise_poly_trajectory_eval_test.sv
